### hdl/fvn_pkg.sv
// Package holding the shared constants and types of the fractal value noise block.
`timescale 1ns / 1ps
package fvn_pkg;
  localparam int unsigned CfgAddrW = 4;
  localparam logic [CfgAddrW-1:0] AddrOctaves = 4'h0;
  localparam logic [CfgAddrW-1:0] AddrAtten   = 4'h4;
  localparam logic [CfgAddrW-1:0] AddrMode    = 4'h8;
  localparam logic [31:0] RngSeedA = 32'd123456789;
  localparam logic [31:0] RngSeedB = 32'd362436069;
  localparam logic [31:0] RngSeedC = 32'd521288629;
  localparam logic [31:0] RngSeedD = 32'd88675123;
  localparam logic [3:0]  OctavesReset = 4'd4;
  localparam logic [15:0] AttenReset   = 16'd16384;

  typedef enum logic {
    ActEvaluate   = 1'b0,
    ActRegenerate = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StEval,
    StDone
  } state_e;

  // Configuration values seen by the evaluator.
  typedef struct packed {
    logic [3:0]  octaves;
    logic [15:0] atten;
    logic        mode;
  } cfg_t;
endpackage

### hdl/fvn_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface fvn_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] position;
  modport source (output valid, action, position, input ready);
  modport sink (input valid, action, position, output ready);
endinterface

interface fvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

### hdl/fractal_value_noise_1d.sv
// Top level of the fractal value noise block: registers, node table, sequencer.
`timescale 1ns / 1ps
// An evaluate word issues one octave a cycle into a six-stage pipeline (a read
// of four interleaved node table banks, the coefficients, three Horner steps
// and the weighting); one evaluate word is in work at a time, and a word
// holds in its done state while the previous result is still waiting. A
// regenerate word fills the table with one xorshift128 draw per cycle and
// gives no result. Configuration is on an APB port at byte addresses 0, 4
// and 8.
module fractal_value_noise_1d #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8,
  parameter int NODE_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fvn_in_if.sink                    in_i,
  fvn_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fvn_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fvn_pkg::*;
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int WW = 30 + MAX_OCTAVES;
  localparam int BD = TABLE_SIZE / 4;
  localparam int BW = (IW > 2) ? IW - 2 : 1;

  cfg_t cfg_q;
  state_e st_q, st_d;
  logic [31:0] ra_q, rb_q, rc_q, rd_q, tx, nd;
  logic [IW-1:0] cnt_q;
  logic [OW-1:0] oct_q, noct;
  logic [31:0] pos_q;
  logic [WW-1:0] wt_q, wtd_q;
  logic [WW+15:0] wprod;
  logic signed [NODE_BITS-1:0] tbl_q [4][BD];
  logic signed [NODE_BITS-1:0] bank_q [4];
  logic [BW-1:0] baddr [4];
  logic filled_q;
  logic signed [NODE_BITS-1:0] node;
  logic signed [63:0] sum_q;
  logic signed [63:0] term;
  logic tvalid, issue, issue_q;
  logic [4:0] pend_q;
  logic [31:0] res_q;
  logic res_v_q;
  logic [IW-1:0] ix, base;
  logic [1:0] sel_q;
  logic [15:0] tf, tf_q;
  logic signed [NODE_BITS-1:0] n0, n1, n2, n3;
  logic [63:0] nx;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{OctavesReset, AttenReset, 1'b0};
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrOctaves: cfg_q.octaves <= pwdata[3:0];
        AddrAtten:   cfg_q.atten   <= pwdata[15:0];
        AddrMode:    cfg_q.mode    <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      AddrOctaves: prdata = {28'd0, cfg_q.octaves};
      AddrAtten:   prdata = {16'd0, cfg_q.atten};
      AddrMode:    prdata = {31'd0, cfg_q.mode};
      default:     prdata = '0;
    endcase
  end

  // Generator step and the node it gives.
  assign tx = ra_q ^ (ra_q << 11);
  assign nd = rd_q ^ (rd_q >> 19) ^ tx ^ (tx >> 8);
  assign node = NODE_BITS'($signed({1'b0, nd[31 -: NODE_BITS]})
                           - $signed({1'b0, 1'b1, {(NODE_BITS-1){1'b0}}}));

  // Table coordinates of the current octave.
  assign nx = {32'd0, pos_q} * 64'(TABLE_SIZE);
  assign ix = nx[32 +: IW];
  assign tf = nx[31:16];
  assign base = ix - IW'(1);

  // The four neighbours are consecutive indices, so each sits in its own bank.
  always_comb begin
    logic [1:0] bsel;
    logic [IW-1:0] bidx;
    for (int b = 0; b < 4; b++) begin
      bsel = 2'(b) - base[1:0];
      bidx = base + IW'(bsel);
      baddr[b] = BW'(bidx >> 2);
    end
  end

  // Node table banks: one fill write and one registered read per bank.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (st_q == StFill && cnt_q[1:0] == 2'(b)) begin
        tbl_q[b][BW'(cnt_q >> 2)] <= node;
      end
      bank_q[b] <= tbl_q[b][baddr[b]];
    end
  end

  // Nodes in neighbour order; the table reads as zero until first filled.
  assign n0 = filled_q ? bank_q[sel_q] : '0;
  assign n1 = filled_q ? bank_q[sel_q + 2'd1] : '0;
  assign n2 = filled_q ? bank_q[sel_q + 2'd2] : '0;
  assign n3 = filled_q ? bank_q[sel_q + 2'd3] : '0;

  assign issue = (st_q == StEval) && (oct_q != '0);
  assign wprod = wt_q * cfg_q.atten;

  fvn_octave #(.NodeBits(NODE_BITS), .WeightW(WW)) u_oct (
    .clk_i, .rst_ni, .valid_i(issue_q), .x0_i(n0), .x1_i(n1), .x2_i(n2), .x3_i(n3),
    .t_i(tf_q), .weight_i(wtd_q), .mode_i(cfg_q.mode), .valid_o(tvalid), .term_o(term)
  );

  // Octave count, clamped.
  always_comb begin
    if (cfg_q.octaves == 4'd0) noct = OW'(1);
    else if (32'(cfg_q.octaves) > MAX_OCTAVES) noct = OW'(MAX_OCTAVES);
    else noct = OW'(cfg_q.octaves);
  end

  // Sequencer.
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_i.valid) st_d = (in_i.action == ActRegenerate) ? StFill : StEval;
      StFill: if (cnt_q == IW'(TABLE_SIZE - 1)) st_d = StIdle;
      StEval: if (oct_q == '0 && pend_q == '0 && !tvalid) st_d = StDone;
      StDone: if (!res_v_q) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end
  assign in_i.ready = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ra_q <= RngSeedA; rb_q <= RngSeedB; rc_q <= RngSeedC; rd_q <= RngSeedD;
      filled_q <= 1'b0;
      cnt_q <= '0;
      oct_q <= '0;
      pend_q <= '0;
      issue_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      issue_q <= issue;
      if (st_q == StIdle && in_i.valid) begin
        cnt_q <= '0;
        oct_q <= noct;
      end
      if (st_q == StFill) begin
        ra_q <= rb_q; rb_q <= rc_q; rc_q <= rd_q; rd_q <= nd;
        filled_q <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (issue) oct_q <= oct_q - 1'b1;
      pend_q <= pend_q + 5'(issue) - 5'(tvalid);
      if (st_q == StDone && !res_v_q) res_v_q <= 1'b1;
      else if (out_o.ready) res_v_q <= 1'b0;
    end
  end

  // Payload: read stage, position, weight and sum.
  always_ff @(posedge clk_i) begin
    sel_q <= base[1:0];
    tf_q  <= tf;
    wtd_q <= wt_q;
    if (st_q == StIdle && in_i.valid) begin
      pos_q <= in_i.position;
      wt_q  <= WW'(32'h4000_0000);
      sum_q <= '0;
    end else begin
      if (issue) begin
        pos_q <= pos_q << 1;
        wt_q  <= wprod[WW+14:15];
      end
      if (tvalid) sum_q <= sum_q + term;
    end
    if (st_q == StDone && !res_v_q) begin
      if (sum_q > 64'sd2147483647) res_q <= 32'h7fff_ffff;
      else if (sum_q < -64'sd2147483648) res_q <= 32'h8000_0000;
      else res_q <= sum_q[31:0];
    end
  end

  assign out_o.valid = res_v_q;
  assign out_o.value = res_q;
endmodule

### hdl/fvn_octave.sv
// Pipelined Catmull-Rom octave evaluator: four nodes and a fraction in, weighted term out.
`timescale 1ns / 1ps
module fvn_octave #(
  parameter int NodeBits = 16,
  parameter int WeightW  = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [NodeBits-1:0] x0_i,
  input  logic signed [NodeBits-1:0] x1_i,
  input  logic signed [NodeBits-1:0] x2_i,
  input  logic signed [NodeBits-1:0] x3_i,
  input  logic [15:0]                t_i,
  input  logic [WeightW-1:0]         weight_i,
  input  logic                       mode_i,
  output logic                       valid_o,
  output logic signed [63:0]         term_o
);
  localparam int CW  = NodeBits + 4;
  localparam int AW  = NodeBits + 6;
  localparam int ShR = (NodeBits > 15) ? NodeBits - 15 : 0;
  localparam int ShL = (NodeBits > 15) ? 0 : 15 - NodeBits;
  localparam int VW  = AW + ShL;
  localparam int PW  = VW + WeightW + 1;

  logic [4:0] vld_q;
  logic signed [CW-1:0] c3_q, c2_q, c1_q, c0_q;
  logic signed [CW-1:0] c1b_q, c0b_q, c0c_q;
  logic [15:0] t1_q, t2_q, t3_q;
  logic [WeightW-1:0] w1_q, w2_q, w3_q, w4_q;
  logic mode1_q, mode2_q, mode3_q, mode4_q;
  logic signed [AW-1:0] a1_q, a2_q, a3_q;
  logic signed [AW+17:0] p1, p2, p3;
  logic signed [VW-1:0] v, av;
  logic signed [PW-1:0] tp;
  logic signed [63:0] term_q;
  logic signed [CW-1:0] e0, e1, e2, e3;

  assign e0 = CW'(x0_i);
  assign e1 = CW'(x1_i);
  assign e2 = CW'(x2_i);
  assign e3 = CW'(x3_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Horner steps, one multiply per stage.
  assign p1 = $signed({{18{c3_q[CW-1]}}, c3_q}) * $signed({1'b0, t1_q});
  assign p2 = $signed(a1_q) * $signed({1'b0, t2_q});
  assign p3 = $signed(a2_q) * $signed({1'b0, t3_q});

  // Octave value in Q16.16, folded for turbulence, then weighted.
  always_comb begin
    v  = (VW'(a3_q) <<< ShL) >>> ShR;
    av = (mode4_q && v < 0) ? -v : v;
    tp = av * $signed({1'b0, w4_q});
  end

  always_ff @(posedge clk_i) begin
    c3_q  <= CW'(-e0 + 3 * e1 - 3 * e2 + e3);
    c2_q  <= CW'(2 * e0 - 5 * e1 + 4 * e2 - e3);
    c1_q  <= CW'(e2 - e0);
    c0_q  <= CW'(2 * e1);
    t1_q  <= t_i;
    w1_q  <= weight_i;
    mode1_q <= mode_i;
    a1_q  <= AW'(p1 >>> 16) + AW'(c2_q);
    c1b_q <= c1_q;
    c0b_q <= c0_q;
    t2_q  <= t1_q;
    w2_q  <= w1_q;
    mode2_q <= mode1_q;
    a2_q  <= AW'(p2 >>> 16) + AW'(c1b_q);
    c0c_q <= c0b_q;
    t3_q  <= t2_q;
    w3_q  <= w2_q;
    mode3_q <= mode2_q;
    a3_q  <= AW'(p3 >>> 16) + AW'(c0c_q);
    w4_q  <= w3_q;
    mode4_q <= mode3_q;
    term_q <= 64'(tp >>> 30);
  end

  assign valid_o = vld_q[4];
  assign term_o  = term_q;
endmodule

### tb/fractal_value_noise_1d_test.sv
// Self-checking testbench for the fractal value noise block, with a scoreboard class.
`timescale 1ns / 1ps
module fractal_value_noise_1d_test;
  import fvn_pkg::*;

  localparam int TableSize  = 256;
  localparam int MaxOctaves = 8;
  localparam int NodeBits   = 16;
  localparam int WatchLimit = 20000;

  // Noise predictor and queue of expected values.
  class noise_scoreboard;
    logic signed [NodeBits-1:0] nodes [TableSize];
    logic [31:0] rng_a, rng_b, rng_c, rng_d;
    logic [3:0]  octaves;
    logic [15:0] atten;
    logic        mode;
    logic signed [31:0] pending_values [$];
    int errors;
    int checked;

    function new();
      foreach (nodes[k]) nodes[k] = '0;
      rng_a = RngSeedA;
      rng_b = RngSeedB;
      rng_c = RngSeedC;
      rng_d = RngSeedD;
      octaves = OctavesReset;
      atten = AttenReset;
      mode = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] next_draw();
      logic [31:0] t;
      t = rng_a ^ (rng_a << 11);
      rng_a = rng_b;
      rng_b = rng_c;
      rng_c = rng_d;
      rng_d = rng_d ^ (rng_d >> 19) ^ t ^ (t >> 8);
      return rng_d;
    endfunction

    // One octave: Catmull-Rom over four wrapped nodes, result in Q16.16.
    function longint octave_sample(logic [31:0] pos);
      logic [63:0] nx;
      int idx;
      longint t16, x0, x1, x2, x3, acc;
      nx = {32'd0, pos} * TableSize;
      idx = int'(nx[63:32]) % TableSize;
      t16 = longint'(nx[31:16]);
      x0 = nodes[(idx + TableSize - 1) % TableSize];
      x1 = nodes[idx];
      x2 = nodes[(idx + 1) % TableSize];
      x3 = nodes[(idx + 2) % TableSize];
      acc = -x0 + 3 * x1 - 3 * x2 + x3;
      acc = ((acc * t16) >>> 16) + (2 * x0 - 5 * x1 + 4 * x2 - x3);
      acc = ((acc * t16) >>> 16) + (x2 - x0);
      acc = ((acc * t16) >>> 16) + 2 * x1;
      return acc >>> (NodeBits - 15);
    endfunction

    // Note an accepted input word.
    function void note_input(logic act, logic [31:0] pos);
      longint sum, v;
      longint unsigned weight;
      int n;
      if (act == ActRegenerate) begin
        for (int k = 0; k < TableSize; k++)
          nodes[k] = NodeBits'((next_draw() >> (32 - NodeBits)) ^ (1 << (NodeBits - 1)));
        return;
      end
      n = octaves;
      if (n < 1) n = 1;
      if (n > MaxOctaves) n = MaxOctaves;
      sum = 0;
      weight = 64'd1 << 30;
      for (int k = 0; k < n; k++) begin
        v = octave_sample(pos);
        if (mode && v < 0) v = -v;
        sum += (v * longint'(weight)) >>> 30;
        weight = (weight * atten) >> 15;
        pos = pos << 1;
      end
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      pending_values.push_back(sum[31:0]);
    endfunction

    // Check an accepted result word against the oldest expectation.
    function void check_result(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result value %0d", $time, got);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_1d i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  noise_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;
  int words_sent = 0;
  int regen_sent = 0;

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) board.check_result(out_ch.value);
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted word at all.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("fractal_value_noise_1d_test: done, errors");
      $finish;
    end
  end

  // One register write, then a wait with the bus left idle.
  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrOctaves) board.octaves = data[3:0];
    else if (addr == AddrAtten) board.atten = data[15:0];
    else if (addr == AddrMode) board.mode = data[0];
    @(posedge clk_i);
  endtask

  // Offer one word and wait until it is taken; valid stays high for a following word.
  task automatic send_word(input logic act, input logic [31:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.action <= act; in_ch.position <= pos;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(act, pos);
    words_sent++;
    if (act == ActRegenerate) regen_sent++;
  endtask

  // Wait for every expected value, then let a regenerate finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_values.size() != 0) @(posedge clk_i);
    repeat (TableSize + 40) @(posedge clk_i);
  endtask

  task automatic random_words(input int count);
    logic [31:0] pos;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: pos = $urandom_range(7) << 29;
        1: pos = 32'hFFFF_FFFF - $urandom_range(3);
        default: pos = $urandom();
      endcase
      send_word(($urandom_range(39) == 0) ? ActRegenerate : ActEvaluate, pos);
    end
  endtask

  initial begin
    int phase_idle [4] = '{0, 79, 0, 37};
    int phase_stall [4] = '{0, 0, 79, 37};
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.position = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: evaluate on the zero table, then regenerate and edge positions.
    send_word(ActEvaluate, 32'h8000_0000);
    send_word(ActRegenerate, '0);
    send_word(ActEvaluate, 32'h0000_0000);
    send_word(ActEvaluate, 32'hFFFF_FFFF);
    send_word(ActEvaluate, 32'h00FF_FFFF);
    send_word(ActEvaluate, 32'hAAAA_5555);
    drain();
    cfg_write(AddrOctaves, 32'd0);
    cfg_write(AddrAtten, 32'd65535);
    cfg_write(AddrMode, 32'd1);
    send_word(ActEvaluate, 32'h5555_AAAA);
    send_word(ActEvaluate, 32'h0123_4567);
    drain();
    cfg_write(AddrOctaves, 32'd15);
    send_word(ActEvaluate, 32'h7FFF_FFFF);
    send_word(ActEvaluate, 32'hFEDC_BA98);
    drain();
    cfg_write(AddrAtten, 32'd0);
    cfg_write(AddrMode, 32'd0);
    send_word(ActEvaluate, 32'h4000_0001);
    drain();

    // Long receiver hold-off while words keep coming.
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      random_words(12);
    join
    drain();

    // Random phases with changing settings and idling.
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = phase_idle[ph % 4];
      recv_stall_pct = phase_stall[ph % 4];
      cfg_write(AddrOctaves, $urandom_range(15));
      cfg_write(AddrAtten, (ph == 3) ? 32'd65535 : $urandom_range(65535));
      cfg_write(AddrMode, $urandom_range(1));
      random_words(115);
      drain();
    end

    $display("Sent %0d words (%0d regenerates), checked %0d noise values", words_sent,
             regen_sent, board.checked);
    $display("over octave counts 0..15, both modes and attenuation extremes.");
    if (board.errors == 0 && board.pending_values.size() == 0)
      $display("fractal_value_noise_1d_test: done, clean");
    else
      $display("fractal_value_noise_1d_test: done, errors");
    $finish;
  end
endmodule
